### hw/rtl/vector_steering_with_search_turns_defines.svh
// assertion macros for the steering block
`ifndef VECTOR_STEERING_WITH_SEARCH_TURNS_DEFINES_SVH
`define VECTOR_STEERING_WITH_SEARCH_TURNS_DEFINES_SVH

// same-cycle implication
`define VSST_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("vsst assertion failed");

// next-cycle implication
`define VSST_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("vsst assertion failed");

`endif

### hw/rtl/vsst_pkg.sv
`timescale 1ns / 1ps

package vsst_pkg;

  typedef enum logic [1:0] {
    CMD_REPULSE = 2'd0,
    CMD_ATTRACT = 2'd1,
    CMD_SEEN    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_RIGHT  = 2'd1,
    MODE_LEFT   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MAX_SPEED  = 2'd0,
    REG_MIN_SPEED  = 2'd1,
    REG_RIGHT_RATE = 2'd2,
    REG_LEFT_RATE  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ITER,
    C_MUL,
    C_FIN
  } cordic_state_t;

  typedef struct packed {
    logic               done;
    logic        [17:0] mag;
    logic signed [15:0] angle;
  } cordic_res_t;

  localparam int          TABLE_LEN      = 24;
  localparam logic [29:0] GAIN_Q30       = 30'd652032875;
  localparam logic [15:0] MAX_SPEED_RST  = 16'd3072;
  localparam logic [15:0] MIN_SPEED_RST  = 16'd0;
  localparam logic [15:0] RIGHT_RATE_RST = 16'hFB33;
  localparam logic [15:0] LEFT_RATE_RST  = 16'd1229;

  // arctangent of 2^-i in q.28
  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097109;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // raise to lo first, then lower to hi
  function automatic logic signed [15:0] clamp_q(input logic signed [18:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
    logic signed [18:0] t;
    logic signed [18:0] lo_w;
    logic signed [18:0] hi_w;
    lo_w = {{3{lo[15]}}, lo};
    hi_w = {{3{hi[15]}}, hi};
    t = v;
    if (t < lo_w) t = lo_w;
    if (t > hi_w) t = hi_w;
    return t[15:0];
  endfunction

endpackage

### hw/rtl/vsst_cordic.sv
`timescale 1ns / 1ps

module vsst_cordic
  import vsst_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [17:0] x_in,
  input  logic signed [17:0] y_in,
  output cordic_res_t        res
);

  localparam int IW = $clog2(STEPS);

  cordic_state_t      state, state_next;
  logic signed [31:0] x, y, z;
  logic signed [31:0] x_step, y_step, z_step;
  logic signed [31:0] dx, dy;
  logic [IW-1:0]      iter;
  logic               zero;
  logic [60:0]        prod;
  logic [60:0]        prod_rnd;
  logic signed [32:0] z_rnd;
  logic               last;

  assign last = (iter == IW'(STEPS - 1));

  // one micro-rotation per cycle
  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    if (!y[31]) begin
      x_step = x + dx;
      y_step = y - dy;
      z_step = z + atan_q28(5'(iter));
    end else begin
      x_step = x - dx;
      y_step = y + dy;
      z_step = z - atan_q28(5'(iter));
    end
    prod_rnd = prod + (61'd1 << 41);
    z_rnd = {z[31], z} + 33'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      res.done <= 1'b0;
    end else begin
      state <= state_next;
      res.done <= (state == C_FIN);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (start) state_next = C_ITER;
      end
      C_ITER: begin
        if (last) state_next = C_MUL;
      end
      C_MUL: begin
        state_next = C_FIN;
      end
      C_FIN: begin
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          x <= {2'b00, x_in, 12'd0};
          y <= {{2{y_in[17]}}, y_in, 12'd0};
          z <= '0;
          iter <= '0;
          zero <= (x_in == '0) && (y_in == '0);
        end
      end
      C_ITER: begin
        x <= x_step;
        y <= y_step;
        z <= z_step;
        iter <= iter + 1'b1;
      end
      C_MUL: begin
        // x never goes negative in vectoring mode
        prod <= 61'(x[30:0]) * 61'(GAIN_Q30);
      end
      C_FIN: begin
        res.mag <= zero ? '0 : prod_rnd[59:42];
        res.angle <= zero ? '0 : z_rnd[31:16];
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/vector_steering_with_search_turns.sv
`timescale 1ns / 1ps

// Steering controller. Words on the item channel update the stored attractive
// and repulsive vectors or the seen flag when accepted and give no result; a
// tick word gives one result word. A tick in follow mode runs a vectoring
// CORDIC of min(CORDIC_STEPS, 24) micro-rotations, one per cycle on a single
// shared add/shift unit, then one gain multiply, rounding and clamping. A tick
// in a search turn skips the CORDIC and goes straight to the hold state; either
// result is loaded into the output register once that register is free.
// The item channel is not ready while a tick is being worked on; one finished
// result may wait in the output register while the next word is taken.
// Configuration writes are taken in any cycle and are meant for idle periods.

module vector_steering_with_search_turns
  import vsst_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic        [1:0]  command,
  input  logic signed [15:0] vec_x,
  input  logic signed [15:0] vec_y,
  input  logic               target_seen,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] linear_speed,
  output logic signed [15:0] angular_rate,
  output logic        [1:0]  mode_before,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic signed [15:0] cfg_data
);

  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  top_state_t         state, state_next;
  logic signed [15:0] max_speed, min_speed, right_turn_rate, left_turn_rate;
  logic signed [15:0] attract_x, attract_y, repulse_x, repulse_y;
  logic               seen_flag, lost_on_right;
  mode_t              steer_mode;
  logic signed [15:0] res_lin, res_ang;
  logic        [1:0]  res_mode;
  logic               accept, is_tick, cordic_start, out_load;
  logic signed [16:0] sum_x, sum_y;
  logic signed [17:0] sx_w;
  logic        [17:0] sx_abs;
  cordic_res_t        cres;

  assign accept = item_valid && item_ready;
  assign is_tick = (command == CMD_TICK);

  always_comb begin
    sum_x = {attract_x[15], attract_x} + {repulse_x[15], repulse_x};
    sum_y = {attract_y[15], attract_y} + {repulse_y[15], repulse_y};
    sx_w = {sum_x[16], sum_x};
    sx_abs = sx_w[17] ? 18'(-sx_w) : 18'(sx_w);
  end

  vsst_cordic #(
    .STEPS(STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .x_in (sx_abs),
    .y_in ({sum_y[16], sum_y}),
    .res  (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cordic_start = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && is_tick) begin
          if (steer_mode == MODE_FOLLOW) begin
            cordic_start = 1'b1;
            state_next = S_RUN;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_RUN: begin
        if (cres.done) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!result_valid || result_ready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_SPEED_RST;
      min_speed <= MIN_SPEED_RST;
      right_turn_rate <= RIGHT_RATE_RST;
      left_turn_rate <= LEFT_RATE_RST;
      attract_x <= '0;
      attract_y <= '0;
      repulse_x <= '0;
      repulse_y <= '0;
      seen_flag <= 1'b0;
      lost_on_right <= 1'b0;
      steer_mode <= MODE_FOLLOW;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_SPEED:  max_speed <= cfg_data;
          REG_MIN_SPEED:  min_speed <= cfg_data;
          REG_RIGHT_RATE: right_turn_rate <= cfg_data;
          REG_LEFT_RATE:  left_turn_rate <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        case (cmd_t'(command))
          CMD_REPULSE: begin
            repulse_x <= vec_x;
            repulse_y <= vec_y;
          end
          CMD_ATTRACT: begin
            attract_x <= vec_x;
            attract_y <= vec_y;
            if (seen_flag) lost_on_right <= !vec_x[15];
          end
          CMD_SEEN: begin
            seen_flag <= target_seen;
          end
          CMD_TICK: begin
            repulse_x <= '0;
            repulse_y <= '0;
            if (steer_mode == MODE_FOLLOW) begin
              if (!seen_flag) steer_mode <= lost_on_right ? MODE_RIGHT : MODE_LEFT;
            end else if (seen_flag) begin
              steer_mode <= MODE_FOLLOW;
            end
          end
          default: ;
        endcase
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      res_mode <= steer_mode;
      if (steer_mode != MODE_FOLLOW) begin
        res_lin <= '0;
        res_ang <= (steer_mode == MODE_RIGHT) ? right_turn_rate : left_turn_rate;
      end
    end
    if (state == S_RUN && cres.done) begin
      res_lin <= clamp_q({1'b0, cres.mag}, min_speed, max_speed);
      res_ang <= clamp_q({{3{cres.angle[15]}}, cres.angle}, min_speed, max_speed);
    end
    if (out_load) begin
      linear_speed <= res_lin;
      angular_rate <= res_ang;
      mode_before <= res_mode;
    end
  end

endmodule

### hw/rtl/vsst_checker.sv
`timescale 1ns / 1ps
`include "vector_steering_with_search_turns_defines.svh"

module vsst_checker
  import vsst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic        [1:0]  command,
  input logic signed [15:0] vec_x,
  input logic signed [15:0] vec_y,
  input logic               target_seen,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [15:0] linear_speed,
  input logic signed [15:0] angular_rate,
  input logic        [1:0]  mode_before,
  input logic               cfg_we,
  input logic        [1:0]  cfg_index,
  input logic signed [15:0] cfg_data
);

  // stalled result word holds
  `VSST_ASSERT_NEXT(a_out_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(linear_speed) && $stable(angular_rate) && $stable(mode_before))

  // search turns never drive forward
  `VSST_ASSERT_NOW(a_turn_no_speed, clk, rst, result_valid && (mode_before != MODE_FOLLOW), linear_speed == 16'sd0)

  // a tick word keeps the block busy
  `VSST_ASSERT_NEXT(a_tick_busy, clk, rst, item_valid && item_ready && (command == CMD_TICK), !item_ready)

  // other words leave the block ready
  `VSST_ASSERT_NEXT(a_update_ready, clk, rst, item_valid && item_ready && (command != CMD_TICK), item_ready)

  // nothing offered right after reset
  `VSST_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_valid)

endmodule

bind vector_steering_with_search_turns vsst_checker u_vsst_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vsst_pkg::*;

  localparam int STEPS = 16;
  localparam longint GAIN = 64'sd652032875;
  localparam longint ATAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  typedef struct {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    mode_t              mode;
  } steer_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic        [1:0]  command = CMD_REPULSE;
  logic signed [15:0] vec_x = '0;
  logic signed [15:0] vec_y = '0;
  logic               target_seen = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [15:0] linear_speed;
  logic signed [15:0] angular_rate;
  logic        [1:0]  mode_before;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = REG_MAX_SPEED;
  logic signed [15:0] cfg_data = '0;

  // predictor state
  logic signed [15:0] spd_max, spd_min, rate_right, rate_left;
  logic signed [15:0] att_x, att_y, rep_x, rep_y;
  logic               seen, lost_right;
  mode_t              mode;

  steer_out_t steer_q[$];
  int errors = 0;
  int words_sent = 0;
  bit calm = 1'b0;

  vector_steering_with_search_turns #(.CORDIC_STEPS(STEPS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin : result_check
    steer_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (steer_q.size() == 0) begin
        $display("%0t: unexpected result word: lin %0d ang %0d mode %0d", $time,
                 linear_speed, angular_rate, mode_before);
        errors++;
      end else begin
        want = steer_q.pop_front();
        if (linear_speed !== want.lin) begin
          $display("%0t: linear_speed expected %0d got %0d", $time, want.lin, linear_speed);
          errors++;
        end
        if (angular_rate !== want.ang) begin
          $display("%0t: angular_rate expected %0d got %0d", $time, want.ang, angular_rate);
          errors++;
        end
        if (mode_before !== want.mode) begin
          $display("%0t: mode_before expected %0d got %0d", $time, want.mode, mode_before);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("vector_steering_with_search_turns regression: fail");
    $finish;
  end

  // magnitude and angle of (|sum_x|, sum_y), vectoring rotations
  function automatic void steer_vector(input longint sum_x, input longint sum_y,
                                      output longint mag, output longint ang);
    longint cx, cy, cz, dx, dy;
    cx = (sum_x < 0) ? -sum_x : sum_x;
    cy = sum_y;
    cz = 0;
    mag = 0;
    ang = 0;
    if (cx != 0 || cy != 0) begin
      cx = cx * 4096;
      cy = cy * 4096;
      for (int i = 0; i < STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + ATAN_Q28[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - ATAN_Q28[i];
        end
      end
      ang = (cz + 32768) >>> 16;
      mag = (cx * GAIN + (longint'(1) <<< 41)) >>> 42;
    end
  endfunction

  // min first, then max, so max wins on an inverted range
  function automatic logic signed [15:0] clip_speed(input longint v);
    longint t;
    t = v;
    if (t < longint'(spd_min)) t = spd_min;
    if (t > longint'(spd_max)) t = spd_max;
    return t[15:0];
  endfunction

  task automatic apply_word(input cmd_t cmd, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic s);
    steer_out_t res;
    longint mag, ang;
    case (cmd)
      CMD_REPULSE: begin
        rep_x = x;
        rep_y = y;
      end
      CMD_ATTRACT: begin
        att_x = x;
        att_y = y;
        if (seen) lost_right = (x >= 0);
      end
      CMD_SEEN: begin
        seen = s;
      end
      default: begin
        res.mode = mode;
        if (mode == MODE_FOLLOW) begin
          steer_vector(longint'(att_x) + longint'(rep_x), longint'(att_y) + longint'(rep_y),
                       mag, ang);
          res.lin = clip_speed(mag);
          res.ang = clip_speed(ang);
          if (!seen) mode = lost_right ? MODE_RIGHT : MODE_LEFT;
        end else begin
          res.lin = '0;
          res.ang = (mode == MODE_RIGHT) ? rate_right : rate_left;
          if (seen) mode = MODE_FOLLOW;
        end
        rep_x = '0;
        rep_y = '0;
        steer_q.push_back(res);
      end
    endcase
  endtask

  task automatic send_word(input cmd_t cmd, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic s);
    if (!calm && $urandom_range(0, 99) < 25) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    vec_x <= x;
    vec_y <= y;
    target_seen <= s;
    do @(posedge clk); while (!item_ready);
    apply_word(cmd, x, y, s);
    words_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic load_speed_regs(input logic signed [15:0] vmax, input logic signed [15:0] vmin,
                                 input logic signed [15:0] vright,
                                 input logic signed [15:0] vleft);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_SPEED;
    cfg_data <= vmax;
    @(posedge clk);
    cfg_index <= REG_MIN_SPEED;
    cfg_data <= vmin;
    @(posedge clk);
    cfg_index <= REG_RIGHT_RATE;
    cfg_data <= vright;
    @(posedge clk);
    cfg_index <= REG_LEFT_RATE;
    cfg_data <= vleft;
    @(posedge clk);
    cfg_we <= 1'b0;
    spd_max = vmax;
    spd_min = vmin;
    rate_right = vright;
    rate_left = vleft;
  endtask

  function automatic logic signed [15:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (pick < 50) return 16'($urandom_range(0, 8192) - 4096);
    return 16'($urandom);
  endfunction

  // one control cycle: optional repulse, attract and seen in either order, tick
  task automatic send_frame();
    logic next_seen;
    next_seen = ($urandom_range(0, 99) < 70) ? seen : !seen;
    if ($urandom_range(0, 1)) send_word(CMD_REPULSE, rand_coord(), rand_coord(), 1'($urandom));
    if ($urandom_range(0, 1)) begin
      send_word(CMD_SEEN, rand_coord(), rand_coord(), next_seen);
      send_word(CMD_ATTRACT, rand_coord(), rand_coord(), 1'($urandom));
    end else begin
      send_word(CMD_ATTRACT, rand_coord(), rand_coord(), 1'($urandom));
      send_word(CMD_SEEN, rand_coord(), rand_coord(), next_seen);
    end
    send_word(CMD_TICK, rand_coord(), rand_coord(), 1'($urandom));
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) send_frame();
      else send_word(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(), 1'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    send_word(CMD_TICK, 16'sh7FFF, 16'sh8000, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_SEEN, 16'sh8000, 16'sh7FFF, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_ATTRACT, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_word(CMD_REPULSE, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_ATTRACT, 16'sh8000, 16'sh8000, 1'b1);
    send_word(CMD_REPULSE, 16'sh8000, 16'sh8000, 1'b0);
    send_word(CMD_TICK, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_word(CMD_ATTRACT, 16'sd4096, 16'sd1024, 1'b0);
    send_word(CMD_SEEN, 16'sh0000, 16'sh0000, 1'b0);
    // not seen: mark stays on the right
    send_word(CMD_ATTRACT, -16'sd4096, 16'sh0000, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b1);
    send_word(CMD_REPULSE, 16'sd1, -16'sd1, 1'b0);
    send_word(CMD_SEEN, 16'shFFFF, 16'shFFFF, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_ATTRACT, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
    send_word(CMD_ATTRACT, -16'sd1, 16'sd1, 1'b1);
    send_word(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0);
  endtask

  task automatic test_default_limits();
    run_traffic(300);
  endtask

  task automatic test_full_range();
    wait_idle();
    load_speed_regs(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    calm = 1'b1;
    run_traffic(300);
    calm = 1'b0;
  endtask

  task automatic test_inverted_range();
    wait_idle();
    load_speed_regs(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    run_traffic(250);
  endtask

  task automatic test_zero_limits();
    wait_idle();
    load_speed_regs(16'sh0000, 16'sh0000, 16'sd1, -16'sd1);
    run_traffic(200);
  endtask

  task automatic test_random_limits();
    int lo, hi, t;
    repeat (4) begin
      lo = $urandom_range(0, 12000) - 6000;
      hi = lo + $urandom_range(0, 12000);
      if ($urandom_range(0, 3) == 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      wait_idle();
      load_speed_regs(16'(hi), 16'(lo), 16'($urandom), 16'($urandom));
      run_traffic(200);
    end
  endtask

  initial begin
    spd_max = 16'sd3072;
    spd_min = 16'sd0;
    rate_right = -16'sd1229;
    rate_left = 16'sd1229;
    att_x = '0;
    att_y = '0;
    rep_x = '0;
    rep_y = '0;
    seen = 1'b0;
    lost_right = 1'b0;
    mode = MODE_FOLLOW;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_default_limits();
    test_full_range();
    test_inverted_range();
    test_zero_limits();
    test_random_limits();
    wait_idle();
    if (errors == 0) begin
      $display("vector_steering_with_search_turns regression: pass");
    end else begin
      $display("vector_steering_with_search_turns regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vsst_pkg.sv
hw/rtl/vsst_cordic.sv
hw/rtl/vector_steering_with_search_turns.sv
hw/rtl/vsst_checker.sv
test/tb_top.sv
